[rtl/rpra_pkg.sv]
// ----------------------------------------------------------------------------
// rpra_pkg
// Shared types and constants of the ring-pair resource allocator.
// ----------------------------------------------------------------------------
package rpra_pkg;

    localparam int SEATS  = 5;
    localparam int SEAT_W = (SEATS > 1) ? $clog2(SEATS) : 1;
    localparam int EAT_W  = $clog2(SEATS / 2 + 1);
    localparam int FREE_W = $clog2(SEATS + 1);

    typedef enum logic {
        REQ_GRAB    = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        OUT_NOTHING  = 3'd0,
        OUT_RIGHT    = 3'd1,
        OUT_LEFT     = 3'd2,
        OUT_EATING   = 3'd3,
        OUT_RELEASED = 3'd4,
        OUT_IGNORED  = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_EAT  = 2'd2
    } t_mode;

    typedef struct packed {
        t_req_type  req_type;
        logic [3:0] seat;
    } t_req;

    typedef struct packed {
        t_outcome   outcome;
        logic [1:0] seat_state;
        logic [3:0] eating_total;
        logic [4:0] free_total;
    } t_result;

endpackage

[rtl/ring_pair_resource_allocator_unit.sv]
// ----------------------------------------------------------------------------
// ring_pair_resource_allocator_unit
// Grants pairs of ring resources to seats on grab and release requests.
//
//   channel   direction   handshake                    payload
//   request   in          i_in_valid / o_in_ready      i_req_type, i_seat
//   result    out         o_out_valid / i_out_ready    o_outcome, o_seat_state,
//                                                      o_eating_total, o_free_total
//
// One request per cycle unless the result channel stalls; results come from the
// result register. Requests are decided combinationally from the input register
// against the state flops, which update at the same edge as the result register.
// Synchronous active-low reset frees all resources and idles all seats.
// A stalled result holds the core; the input register still takes one request.
// ----------------------------------------------------------------------------
module ring_pair_resource_allocator_unit
    import rpra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic [3:0] i_seat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_outcome,
    output logic [1:0] o_seat_state,
    output logic [3:0] o_eating_total,
    output logic [4:0] o_free_total
);

    t_req    in_req;
    t_req    req;
    t_result core_result;
    t_result out_result;
    logic    req_valid;
    logic    out_free;
    logic    advance;

    assign in_req.req_type = t_req_type'(i_req_type);
    assign in_req.seat     = i_seat;
    assign advance         = req_valid && out_free;

    rpra_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (in_req),
        .i_take  (advance),
        .o_valid (req_valid),
        .o_req   (req)
    );

    rpra_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_req    (req),
        .o_result (core_result)
    );

    rpra_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_outcome      = out_result.outcome;
    assign o_seat_state   = out_result.seat_state;
    assign o_eating_total = out_result.eating_total;
    assign o_free_total   = out_result.free_total;

endmodule

[rtl/rpra_in_reg.sv]
// ----------------------------------------------------------------------------
// rpra_in_reg
// Input register: holds one request until the allocator core takes it.
// ----------------------------------------------------------------------------
module rpra_in_reg
    import rpra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    input  logic i_take,
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

[rtl/rpra_core.sv]
// ----------------------------------------------------------------------------
// rpra_core
// Resource and seat state, and the grab/release decision for one request.
// ----------------------------------------------------------------------------
module rpra_core
    import rpra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_req    i_req,
    output t_result o_result
);

    logic [SEATS-1:0]  r_taken;
    logic [SEAT_W-1:0] r_owner [SEATS];
    t_mode             r_mode  [SEATS];
    logic [EAT_W-1:0]  r_eat;
    logic [FREE_W-1:0] r_free;

    logic [SEATS-1:0]  n_taken;
    logic [SEAT_W-1:0] n_owner [SEATS];
    t_mode             n_mode  [SEATS];
    logic [EAT_W-1:0]  n_eat;
    logic [FREE_W-1:0] n_free;

    logic              seat_ok;
    logic [SEAT_W-1:0] s;
    logic [SEAT_W-1:0] rr;
    logic [SEAT_W-1:0] lr;
    logic              own_r;
    logic              own_l;
    logic [1:0]        take_cnt;
    logic [FREE_W:0]   free_add;
    t_mode             mode;
    t_outcome          outcome;

    assign seat_ok  = {1'b0, i_req.seat} < 5'(SEATS);
    assign s        = i_req.seat[SEAT_W-1:0];
    assign rr       = s;
    assign lr       = (s == SEAT_W'(SEATS - 1)) ? '0 : s + 1'b1;
    assign own_r    = r_taken[rr] && (r_owner[rr] == s);
    assign own_l    = r_taken[lr] && (r_owner[lr] == s);
    assign free_add = {1'b0, r_free} + (FREE_W + 1)'(2);

    always_comb begin
        n_taken  = r_taken;
        n_owner  = r_owner;
        n_mode   = r_mode;
        n_eat    = r_eat;
        n_free   = r_free;
        take_cnt = 2'd0;
        mode     = MODE_NONE;
        outcome  = OUT_NOTHING;
        if (seat_ok) begin
            mode = r_mode[s];
            if (i_req.req_type == REQ_RELEASE) begin
                if (mode == MODE_EAT) begin
                    n_taken[lr] = 1'b0;
                    n_taken[rr] = 1'b0;
                    if (r_eat != '0) begin
                        n_eat = r_eat - 1'b1;
                    end
                    n_free  = (free_add > (FREE_W + 1)'(SEATS)) ?
                              FREE_W'(SEATS) : free_add[FREE_W-1:0];
                    mode    = MODE_NONE;
                    outcome = OUT_RELEASED;
                end else begin
                    outcome = OUT_IGNORED;
                end
            end else begin
                case (mode)
                    MODE_ONE: begin
                        if (own_l) begin
                            if (!r_taken[rr]) begin
                                n_taken[rr] = 1'b1;
                                n_owner[rr] = s;
                                take_cnt    = 2'd1;
                                n_eat       = r_eat + 1'b1;
                                mode        = MODE_EAT;
                                outcome     = OUT_EATING;
                            end
                        end else if (own_r) begin
                            if (!r_taken[lr]) begin
                                n_taken[lr] = 1'b1;
                                n_owner[lr] = s;
                                take_cnt    = 2'd1;
                                n_eat       = r_eat + 1'b1;
                                mode        = MODE_EAT;
                                outcome     = OUT_EATING;
                            end
                        end
                    end
                    MODE_NONE: begin
                        // deadlock guard: last free resource while nobody eats
                        if (!(r_free == FREE_W'(1) && r_eat == '0)) begin
                            if (!r_taken[rr] && !r_taken[lr]) begin
                                n_taken[rr] = 1'b1;
                                n_owner[rr] = s;
                                n_taken[lr] = 1'b1;
                                n_owner[lr] = s;
                                take_cnt    = 2'd2;
                                n_eat       = r_eat + 1'b1;
                                mode        = MODE_EAT;
                                outcome     = OUT_EATING;
                            end else if (!r_taken[rr]) begin
                                n_taken[rr] = 1'b1;
                                n_owner[rr] = s;
                                take_cnt    = 2'd1;
                                mode        = MODE_ONE;
                                outcome     = OUT_RIGHT;
                            end else if (!r_taken[lr]) begin
                                n_taken[lr] = 1'b1;
                                n_owner[lr] = s;
                                take_cnt    = 2'd1;
                                mode        = MODE_ONE;
                                outcome     = OUT_LEFT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (take_cnt != 2'd0) begin
                n_free = (r_free > FREE_W'(take_cnt)) ? r_free - FREE_W'(take_cnt) : '0;
            end
            n_mode[s] = mode;
        end
    end

    assign o_result.outcome      = outcome;
    assign o_result.seat_state   = mode;
    assign o_result.eating_total = 4'(n_eat);
    assign o_result.free_total   = 5'(n_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_eat   <= '0;
            r_free  <= FREE_W'(SEATS);
            for (int i = 0; i < SEATS; i++) begin
                r_mode[i] <= MODE_NONE;
            end
        end else if (i_en) begin
            r_taken <= n_taken;
            r_eat   <= n_eat;
            r_free  <= n_free;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_owner <= n_owner;
        end
    end

endmodule

[rtl/rpra_out_reg.sv]
// ----------------------------------------------------------------------------
// rpra_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module rpra_out_reg
    import rpra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
